[rtl/tlptw_pkg.sv]
// Shared types, codes and defaults for the three-level page table walker.
`timescale 1ns / 1ps

package tlptw_pkg;

  localparam int unsigned MAX_TABLES_DEF = 16;
  localparam int unsigned ENTRIES_PER_TABLE = 8;

  localparam logic [1:0] ACT_TAG   = 2'd0;
  localparam logic [1:0] ACT_ENTRY = 2'd1;
  localparam logic [1:0] ACT_XLATE = 2'd2;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_EXEC  = 2'd2;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_BOUNDS  = 3'd1;
  localparam logic [2:0] STAT_MISSING = 3'd2;
  localparam logic [2:0] STAT_INVALID = 3'd3;
  localparam logic [2:0] STAT_ILLEGAL = 3'd4;

  localparam int unsigned BIT_VALID = 4;
  localparam int unsigned BIT_R     = 3;
  localparam int unsigned BIT_W     = 2;
  localparam int unsigned BIT_X     = 1;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  table_slot;
    logic [2:0]  entry_index;
    logic [19:0] write_value;
    logic [1:0]  access_kind;
    logic [15:0] virt_addr;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  fault_level;
    logic [2:0]  fault_index;
    logic [14:0] fault_frame;
    logic [14:0] leaf_frame;
    logic [2:0]  access_rights;
    logic [19:0] phys_addr;
  } out_t;

  typedef struct packed {
    logic        tag_we;
    logic        ent_we;
    logic [3:0]  slot;
    logic [2:0]  index;
    logic [19:0] value;
  } wr_t;

endpackage

[rtl/tlptw_store.sv]
// Tag and entry memories of the walker, one write port and registered reads.
`timescale 1ns / 1ps

module tlptw_store #(
  parameter int unsigned MAX_TABLES = tlptw_pkg::MAX_TABLES_DEF,
  parameter int unsigned SLOT_W     = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1
) (
  input  logic                clk_i,
  input  tlptw_pkg::wr_t      wr_i,
  input  logic [SLOT_W-1:0]   tag_raddr_i,
  input  logic [SLOT_W+2:0]   ent_raddr_i,
  output logic [14:0]         tag_rdata_o,
  output logic [19:0]         ent_rdata_o
);

  localparam int unsigned ENT_DEPTH = MAX_TABLES * tlptw_pkg::ENTRIES_PER_TABLE;

  logic [14:0] tag_mem [MAX_TABLES];
  logic [19:0] ent_mem [ENT_DEPTH];

  logic [8:0]        slot_ext;
  logic              in_range;
  logic [SLOT_W-1:0] wslot;

  assign slot_ext = 9'(wr_i.slot);
  assign in_range = slot_ext < 9'(MAX_TABLES);
  assign wslot    = slot_ext[SLOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.tag_we && in_range) begin
      tag_mem[wslot] <= wr_i.value[14:0];
    end
    if (wr_i.ent_we && in_range) begin
      ent_mem[{wslot, wr_i.index}] <= wr_i.value;
    end
    tag_rdata_o <= tag_mem[tag_raddr_i];
    ent_rdata_o <= ent_mem[ent_raddr_i];
  end

endmodule

[rtl/three_level_page_table_walker.sv]
// Top level: three-level page table walker with tag search sequencer.
//
//   channel | direction | handshake         | word
//   in      | input     | in_valid/in_stall | tlptw_pkg::in_t
//   out     | output    | out_valid/stall   | tlptw_pkg::out_t
//   cfg     | input     | valid/ready       | tables_in_use, 5 bits
//
// A translate in range walks three levels; each level scans slot tags one per
// cycle through the tag memory read port until a tag matches the frame, or
// reports a missing table once all slots below the limit are read, then the
// result word goes to the output register. Reset clears the sequencer and
// tables_in_use; memory contents are kept. The input stalls while a walk
// runs or its word waits.
`timescale 1ns / 1ps

module three_level_page_table_walker #(
  parameter int unsigned MAX_TABLES = tlptw_pkg::MAX_TABLES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tlptw_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tlptw_pkg::out_t out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [4:0]      cfg_data_i
);

  localparam int unsigned SLOT_W = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_TABLES + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_ENTRY  = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [SLOT_W-1:0] pslot_q, pslot_d;
  logic [1:0]        lvl_q, lvl_d;
  logic [4:0]        tiu_q;
  logic              out_valid_q, out_valid_d;

  logic [14:0]       frame_q, frame_d;
  logic [8:0]        page_q, page_d;
  logic [4:0]        ofs_q, ofs_d;
  logic [1:0]        kind_q, kind_d;
  tlptw_pkg::out_t   res_q, res_d;
  tlptw_pkg::out_t   out_q;

  logic              in_acc, load_out, issue, match, denied;
  logic [2:0]        cur_idx;
  logic [8:0]        cfg_ext, lim9;
  logic [CNT_W-1:0]  lim;
  logic [14:0]       tag_rdata;
  logic [19:0]       ent;
  tlptw_pkg::wr_t    wr;

  assign in_stall_o  = state_q != S_IDLE;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign wr.tag_we = in_acc && in_data_i.action == tlptw_pkg::ACT_TAG;
  assign wr.ent_we = in_acc && in_data_i.action == tlptw_pkg::ACT_ENTRY;
  assign wr.slot   = in_data_i.table_slot;
  assign wr.index  = in_data_i.entry_index;
  assign wr.value  = in_data_i.write_value;

  assign cfg_ext = 9'(tiu_q);
  assign lim9    = (cfg_ext < 9'(MAX_TABLES)) ? cfg_ext : 9'(MAX_TABLES);
  assign lim     = lim9[CNT_W-1:0];

  always_comb begin
    case (lvl_q)
      2'd0:    cur_idx = page_q[8:6];
      2'd1:    cur_idx = page_q[5:3];
      default: cur_idx = page_q[2:0];
    endcase
  end

  tlptw_store #(
    .MAX_TABLES (MAX_TABLES),
    .SLOT_W     (SLOT_W)
  ) u_store (
    .clk_i       (clk_i),
    .wr_i        (wr),
    .tag_raddr_i (cnt_q[SLOT_W-1:0]),
    .ent_raddr_i ({pslot_q, cur_idx}),
    .tag_rdata_o (tag_rdata),
    .ent_rdata_o (ent)
  );

  assign issue  = cnt_q < lim;
  assign match  = pend_q && tag_rdata == frame_q;
  assign denied = (kind_q == tlptw_pkg::KIND_READ  && !ent[tlptw_pkg::BIT_R]) ||
                  (kind_q == tlptw_pkg::KIND_WRITE && !ent[tlptw_pkg::BIT_W]) ||
                  (kind_q == tlptw_pkg::KIND_EXEC  && !ent[tlptw_pkg::BIT_X]);
  assign load_out = state_q == S_DONE && (!out_valid_q || !out_stall_i);
  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    pslot_d = pslot_q;
    lvl_d   = lvl_q;
    frame_d = frame_q;
    page_d  = page_q;
    ofs_d   = ofs_q;
    kind_d  = kind_q;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.action == tlptw_pkg::ACT_XLATE) begin
          page_d  = in_data_i.virt_addr[13:5];
          ofs_d   = in_data_i.virt_addr[4:0];
          kind_d  = in_data_i.access_kind;
          frame_d = '0;
          lvl_d   = '0;
          cnt_d   = '0;
          pend_d  = 1'b0;
          res_d   = '0;
          if (in_data_i.virt_addr[15:14] != 2'b00) begin
            res_d.status = tlptw_pkg::STAT_BOUNDS;
            state_d      = S_DONE;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (match) begin
          pend_d  = 1'b0;
          state_d = S_ENTRY;
        end else if (!pend_q && !issue) begin
          res_d.status      = tlptw_pkg::STAT_MISSING;
          res_d.fault_level = lvl_q;
          res_d.fault_frame = frame_q;
          state_d           = S_DONE;
        end else begin
          pend_d  = issue;
          pslot_d = cnt_q[SLOT_W-1:0];
          if (issue) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      S_ENTRY: begin
        if (!ent[tlptw_pkg::BIT_VALID]) begin
          res_d.status      = tlptw_pkg::STAT_INVALID;
          res_d.fault_level = lvl_q;
          res_d.fault_index = cur_idx;
          res_d.fault_frame = frame_q;
          state_d           = S_DONE;
        end else if (lvl_q != 2'd2) begin
          frame_d = ent[19:5];
          lvl_d   = lvl_q + 2'd1;
          cnt_d   = '0;
          pend_d  = 1'b0;
          state_d = S_SEARCH;
        end else begin
          res_d.leaf_frame    = ent[19:5];
          res_d.access_rights = ent[3:1];
          if (denied) begin
            res_d.status      = tlptw_pkg::STAT_ILLEGAL;
            res_d.fault_level = 2'd2;
            res_d.fault_index = cur_idx;
            res_d.fault_frame = frame_q;
          end else begin
            res_d.status    = tlptw_pkg::STAT_OK;
            res_d.phys_addr = {ent[19:5], ofs_q};
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pslot_q     <= '0;
      lvl_q       <= '0;
      tiu_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      pslot_q     <= pslot_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tiu_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    page_q  <= page_d;
    ofs_q   <= ofs_d;
    kind_q  <= kind_d;
    res_q   <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

endmodule

[verif/three_level_page_table_walker_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the page table walker: directed table of words, then random phases.

module three_level_page_table_walker_test;

  localparam int unsigned SLOTS = tlptw_pkg::MAX_TABLES_DEF;
  localparam int unsigned EPT = tlptw_pkg::ENTRIES_PER_TABLE;
  localparam logic [1:0] ACT_NOP = 2'd3;
  localparam logic [1:0] KIND_OTHER = 2'd3;
  localparam logic [15:0] ADDR_LIMIT = 16'h4000;
  localparam int unsigned SETTLE = 80;

  typedef struct packed {
    logic            cfg;
    logic [4:0]      limit;
    tlptw_pkg::in_t  word;
    logic            typed;
    tlptw_pkg::out_t want;
  } row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid = 1'b0;
  tlptw_pkg::in_t  in_data = '0;
  logic            in_stall;
  logic            out_valid;
  logic            out_stall = 1'b0;
  tlptw_pkg::out_t out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [4:0]      cfg_data = '0;

  logic [14:0]     tag_mem [SLOTS];
  logic [19:0]     entry_mem [SLOTS*EPT];
  logic [4:0]      table_limit = '0;
  tlptw_pkg::out_t pending_xlate [$];
  row_t            plan [$];
  int              errors = 0;
  int              words_sent = 0;
  int              results_seen = 0;
  int              cfg_writes = 0;
  int              status_seen [5];
  bit              calm = 1'b0;
  int              stall_run = 0;

  three_level_page_table_walker #(
    .MAX_TABLES(SLOTS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int find_table(input logic [14:0] frame);
    int lim;
    lim = (int'(table_limit) > int'(SLOTS)) ? int'(SLOTS) : int'(table_limit);
    for (int i = 0; i < lim; i++)
      if (tag_mem[i] == frame) return i;
    return -1;
  endfunction

  function automatic tlptw_pkg::out_t walk_translate(input tlptw_pkg::in_t w);
    tlptw_pkg::out_t r;
    logic [2:0]      idx [3];
    logic [14:0]     frame;
    logic [19:0]     ent;
    int              s;
    logic            denied;
    r = '0;
    frame = '0;
    ent = '0;
    if (w.virt_addr >= ADDR_LIMIT) begin
      r.status = tlptw_pkg::STAT_BOUNDS;
      return r;
    end
    idx[0] = w.virt_addr[13:11];
    idx[1] = w.virt_addr[10:8];
    idx[2] = w.virt_addr[7:5];
    for (int lvl = 0; lvl < 3; lvl++) begin
      s = find_table(frame);
      if (s < 0) begin
        r.status = tlptw_pkg::STAT_MISSING;
        r.fault_level = 2'(lvl);
        r.fault_frame = frame;
        return r;
      end
      ent = entry_mem[s * EPT + idx[lvl]];
      if (!ent[tlptw_pkg::BIT_VALID]) begin
        r.status = tlptw_pkg::STAT_INVALID;
        r.fault_level = 2'(lvl);
        r.fault_index = idx[lvl];
        r.fault_frame = frame;
        return r;
      end
      if (lvl < 2) frame = ent[19:5];
    end
    r.leaf_frame = ent[19:5];
    r.access_rights = ent[3:1];
    case (w.access_kind)
      tlptw_pkg::KIND_READ:  denied = !ent[tlptw_pkg::BIT_R];
      tlptw_pkg::KIND_WRITE: denied = !ent[tlptw_pkg::BIT_W];
      tlptw_pkg::KIND_EXEC:  denied = !ent[tlptw_pkg::BIT_X];
      default:               denied = 1'b0;
    endcase
    if (denied) begin
      r.status = tlptw_pkg::STAT_ILLEGAL;
      r.fault_level = 2'd2;
      r.fault_index = idx[2];
      r.fault_frame = frame;
      return r;
    end
    r.status = tlptw_pkg::STAT_OK;
    r.phys_addr = {ent[19:5], w.virt_addr[4:0]};
    return r;
  endfunction

  // updates the table store for writes; returns 1 when the word yields a result
  function automatic bit absorb_word(input tlptw_pkg::in_t w, output tlptw_pkg::out_t r);
    r = '0;
    case (w.action)
      tlptw_pkg::ACT_TAG: begin
        tag_mem[w.table_slot] = w.write_value[14:0];
        return 1'b0;
      end
      tlptw_pkg::ACT_ENTRY: begin
        entry_mem[{w.table_slot, w.entry_index}] = w.write_value;
        return 1'b0;
      end
      tlptw_pkg::ACT_XLATE: begin
        r = walk_translate(w);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic row_t word_row(input logic [1:0] act, input logic [3:0] slot,
                                    input logic [2:0] idx, input logic [19:0] val,
                                    input logic [1:0] kind, input logic [15:0] addr);
    row_t r;
    r = '0;
    r.word.action = act;
    r.word.table_slot = slot;
    r.word.entry_index = idx;
    r.word.write_value = val;
    r.word.access_kind = kind;
    r.word.virt_addr = addr;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [4:0] v);
    row_t r;
    r = '0;
    r.cfg = 1'b1;
    r.limit = v;
    return r;
  endfunction

  function automatic row_t fault_row(input logic [15:0] addr, input logic [1:0] kind,
                                     input logic [2:0] st, input logic [1:0] lvl,
                                     input logic [14:0] frame);
    row_t r;
    r = word_row(tlptw_pkg::ACT_XLATE, '0, '0, '0, kind, addr);
    r.typed = 1'b1;
    r.want.status = st;
    r.want.fault_level = lvl;
    r.want.fault_frame = frame;
    return r;
  endfunction

  function automatic tlptw_pkg::in_t random_word();
    tlptw_pkg::in_t w;
    logic [63:0]    raw;
    int             pick;
    raw = {$urandom, $urandom};
    w = raw[$bits(tlptw_pkg::in_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      w.action = ACT_NOP;
    end else if (pick < 18) begin
      w.action = tlptw_pkg::ACT_TAG;
      if ($urandom_range(0, 4) != 0) w.write_value[14:0] = 15'($urandom_range(0, 7));
    end else if (pick < 52) begin
      w.action = tlptw_pkg::ACT_ENTRY;
      if ($urandom_range(0, 6) != 0) w.write_value[19:5] = 15'($urandom_range(0, 7));
      w.write_value[tlptw_pkg::BIT_VALID] = ($urandom_range(0, 9) != 0);
    end else begin
      w.action = tlptw_pkg::ACT_XLATE;
      if ($urandom_range(0, 9) != 0) w.virt_addr[15:14] = 2'b00;
    end
    return w;
  endfunction

  task automatic send_word(input tlptw_pkg::in_t w, input bit typed,
                           input tlptw_pkg::out_t want);
    tlptw_pkg::out_t r;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    words_sent++;
    if (absorb_word(w, r)) pending_xlate.push_back(typed ? want : r);
  endtask

  task automatic set_table_limit(input logic [4:0] v);
    in_valid <= 1'b0;
    while (pending_xlate.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    table_limit = v;
    cfg_writes++;
  endtask

  task automatic check_field(input string what, input logic [19:0] want,
                             input logic [19:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    tlptw_pkg::out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.status <= tlptw_pkg::STAT_ILLEGAL) status_seen[out_data.status]++;
      if (pending_xlate.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word expected none got %h", $time, out_data);
      end else begin
        want = pending_xlate.pop_front();
        check_field("status", 20'(want.status), 20'(out_data.status));
        check_field("fault_level", 20'(want.fault_level), 20'(out_data.fault_level));
        check_field("fault_index", 20'(want.fault_index), 20'(out_data.fault_index));
        check_field("fault_frame", 20'(want.fault_frame), 20'(out_data.fault_frame));
        check_field("leaf_frame", 20'(want.leaf_frame), 20'(out_data.leaf_frame));
        check_field("access_rights", 20'(want.access_rights),
                    20'(out_data.access_rights));
        check_field("phys_addr", want.phys_addr, out_data.phys_addr);
      end
    end
    // random stall bursts, each followed by a release of the stall
    if (!rst_ni || calm) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(0, 14);
    end
  end

  initial begin
    logic [4:0] lim;
    int         n;
    // limit is zero after reset: no tag is searched
    plan.push_back(fault_row(16'h0000, tlptw_pkg::KIND_READ, tlptw_pkg::STAT_MISSING,
                             2'd0, 15'h0000));
    plan.push_back(fault_row(16'h3FFF, tlptw_pkg::KIND_EXEC, tlptw_pkg::STAT_MISSING,
                             2'd0, 15'h0000));
    plan.push_back(fault_row(16'h4000, tlptw_pkg::KIND_READ, tlptw_pkg::STAT_BOUNDS,
                             2'd0, 15'h0000));
    plan.push_back(fault_row(16'hFFFF, KIND_OTHER, tlptw_pkg::STAT_BOUNDS, 2'd0, 15'h0000));
    plan.push_back(word_row(ACT_NOP, 4'hF, 3'h7, 20'hFFFFF, KIND_OTHER, 16'hFFFF));
    // define the whole store before any search
    for (int s = 0; s < SLOTS; s++) begin
      plan.push_back(word_row(tlptw_pkg::ACT_TAG, 4'(s), '0, 20'h00100 + 20'(s),
                              tlptw_pkg::KIND_READ, '0));
      for (int e = 0; e < EPT; e++)
        plan.push_back(word_row(tlptw_pkg::ACT_ENTRY, 4'(s), 3'(e), 20'h00000,
                                tlptw_pkg::KIND_READ, '0));
    end
    // chain: slot 3 (frame 0) -> slot 5 (0x105) -> slot 10 (0x10A)
    plan.push_back(word_row(tlptw_pkg::ACT_TAG, 4'd3, '0, 20'hF8000,
                            tlptw_pkg::KIND_READ, '0));
    plan.push_back(word_row(tlptw_pkg::ACT_ENTRY, 4'd3, 3'd7, {15'h0105, 5'b10000},
                            tlptw_pkg::KIND_READ, '0));
    plan.push_back(word_row(tlptw_pkg::ACT_ENTRY, 4'd5, 3'd0, {15'h010A, 5'b10000},
                            tlptw_pkg::KIND_READ, '0));
    plan.push_back(word_row(tlptw_pkg::ACT_ENTRY, 4'd10, 3'd5, {15'h7FFF, 5'b11011},
                            tlptw_pkg::KIND_READ, '0));
    plan.push_back(cfg_row(5'd16));
    plan.push_back(word_row(tlptw_pkg::ACT_XLATE, '0, '0, '0, tlptw_pkg::KIND_READ, 16'h38BF));
    plan.push_back(word_row(tlptw_pkg::ACT_XLATE, '0, '0, '0, tlptw_pkg::KIND_WRITE, 16'h38BF));
    plan.push_back(word_row(tlptw_pkg::ACT_XLATE, '0, '0, '0, tlptw_pkg::KIND_EXEC, 16'h38BF));
    plan.push_back(word_row(tlptw_pkg::ACT_XLATE, '0, '0, '0, KIND_OTHER, 16'h38BF));
    plan.push_back(cfg_row(5'd8));
    plan.push_back(fault_row(16'h38BF, tlptw_pkg::KIND_READ, tlptw_pkg::STAT_MISSING,
                             2'd2, 15'h010A));
    plan.push_back(cfg_row(5'd31));
    plan.push_back(word_row(tlptw_pkg::ACT_XLATE, '0, '0, '0, tlptw_pkg::KIND_READ, 16'h38BF));
    plan.push_back(fault_row(16'h0000, tlptw_pkg::KIND_READ, tlptw_pkg::STAT_INVALID,
                             2'd0, 15'h0000));
    plan.push_back(word_row(tlptw_pkg::ACT_XLATE, '0, '0, '0, tlptw_pkg::KIND_READ, 16'h3900));
    plan.push_back(word_row(tlptw_pkg::ACT_XLATE, '0, '0, '0, tlptw_pkg::KIND_READ, 16'h3800));
    plan.push_back(word_row(tlptw_pkg::ACT_ENTRY, 4'd3, 3'd6, {15'h0055, 5'b10000},
                            tlptw_pkg::KIND_READ, '0));
    plan.push_back(fault_row(16'h3000, tlptw_pkg::KIND_READ, tlptw_pkg::STAT_MISSING,
                             2'd1, 15'h0055));
    plan.push_back(word_row(tlptw_pkg::ACT_ENTRY, 4'd10, 3'd5, {15'h0000, 5'b10100},
                            tlptw_pkg::KIND_READ, '0));
    plan.push_back(word_row(tlptw_pkg::ACT_XLATE, '0, '0, '0, tlptw_pkg::KIND_READ, 16'h38BF));
    plan.push_back(word_row(tlptw_pkg::ACT_XLATE, '0, '0, '0, tlptw_pkg::KIND_WRITE, 16'h38BF));
    plan.push_back(word_row(tlptw_pkg::ACT_XLATE, '0, '0, '0, tlptw_pkg::KIND_EXEC, 16'h38BF));
    // lower slot with the same tag wins the search
    plan.push_back(word_row(tlptw_pkg::ACT_TAG, 4'd1, '0, 20'h00105,
                            tlptw_pkg::KIND_READ, '0));
    plan.push_back(word_row(tlptw_pkg::ACT_XLATE, '0, '0, '0, tlptw_pkg::KIND_READ, 16'h38BF));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].cfg) set_table_limit(plan[i].limit);
      else send_word(plan[i].word, plan[i].typed, plan[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: lim = 5'd16;
        1: lim = 5'd31;
        2: lim = 5'd4;
        3: lim = 5'd1;
        4: lim = 5'd0;
        5: lim = 5'd9;
        6: lim = 5'($urandom_range(0, 31));
        default: lim = 5'd16;
      endcase
      set_table_limit(lim);
      calm = (ph == 7);
      n = (lim == 0) ? 40 : 110;
      repeat (n) send_word(random_word(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_xlate.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    $display("words accepted %0d, translations checked %0d, limit writes %0d, mismatches %0d",
             words_sent, results_seen, cfg_writes, errors);
    $display("status mix: ok %0d, bounds %0d, missing %0d, invalid %0d, illegal %0d",
             status_seen[tlptw_pkg::STAT_OK], status_seen[tlptw_pkg::STAT_BOUNDS],
             status_seen[tlptw_pkg::STAT_MISSING], status_seen[tlptw_pkg::STAT_INVALID],
             status_seen[tlptw_pkg::STAT_ILLEGAL]);
    if (errors == 0) begin
      $display("three_level_page_table_walker_test: PASS");
    end else begin
      $display("three_level_page_table_walker_test: FAIL");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("%0t: timed out with %0d results outstanding", $time, pending_xlate.size());
    $display("three_level_page_table_walker_test: FAIL");
    $finish;
  end

endmodule
